/* rtl/core/pcs_pkg.sv */
package pcs_pkg;

   localparam int unsigned RatioCount = 5;
   localparam logic [31:0] CounterMaxDefault = 32'd65535;
   localparam int unsigned NumPrescalersDefault = 5;

   localparam logic [31:0] ClockHzReset = 32'd16000000;
   localparam logic [15:0] MaxFreqReset = 16'd65535;

   localparam logic [0:0] CsrClockHz = 1'b0;
   localparam logic [0:0] CsrMaxFreq = 1'b1;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusTooFast = 2'd1;
   localparam logic [1:0] StatusNoPrescaler = 2'd2;

   // prescaler ratios as shift amounts: 1, 8, 64, 256, 1024
   function automatic logic [3:0] ratio_shift(input logic [2:0] idx);
      logic [3:0] s;
      begin
         case (idx)
            3'd0: s = 4'd0;
            3'd1: s = 4'd3;
            3'd2: s = 4'd6;
            3'd3: s = 4'd8;
            default: s = 4'd10;
         endcase
         return s;
      end
   endfunction

   typedef struct packed {
      logic [2:0]  select_code;
      logic [10:0] divide_ratio;
      logic [15:0] compare_top;
      logic [1:0]  status;
   } result_type;

   // one candidate after division
   typedef struct packed {
      logic        ok;
      logic [31:0] rounded;
      logic [31:0] num;
      logic [31:0] den;
   } cand_type;

endpackage

/* rtl/core/pcs_if.sv */
interface pcs_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] wanted_freq;
   modport source (output valid, output wanted_freq, input ready);
   modport sink (input valid, input wanted_freq, output ready);
endinterface

interface pcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  select_code;
   logic [10:0] divide_ratio;
   logic [15:0] compare_top;
   logic [1:0]  status;
   modport source (output valid, output select_code, output divide_ratio,
                   output compare_top, output status, input ready);
   modport sink (input valid, input select_code, input divide_ratio,
                 input compare_top, input status, output ready);
endinterface

/* rtl/core/pcs_div_pipe.sv */
// Pipelined restoring divider: one quotient bit per stage, 32 stages.
module pcs_div_pipe #(
   parameter int unsigned TagW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [31:0]     in_num,
   input  logic [31:0]     in_den,
   input  logic [TagW-1:0] in_tag,
   output logic            out_valid,
   output logic [31:0]     out_quo,
   output logic [31:0]     out_rem,
   output logic [31:0]     out_den,
   output logic [TagW-1:0] out_tag
);
   localparam int unsigned Steps = 32;

   logic [Steps-1:0]         v_ff;
   logic [31:0]              rem_ff [Steps];
   logic [31:0]              quo_ff [Steps];
   logic [31:0]              den_ff [Steps];
   logic [TagW-1:0]          tag_ff [Steps];

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[Steps-2:0], in_valid};
   end

   // one shift-subtract step per stage
   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [31:0]     rem_src;
      logic [31:0]     quo_src;
      logic [31:0]     den_src;
      logic [TagW-1:0] tag_src;
      logic [32:0]     trial_in;
      logic [32:0]     diff_in;
      if (s == 0) begin : g_head
         assign rem_src = '0;
         assign quo_src = in_num;
         assign den_src = in_den;
         assign tag_src = in_tag;
      end else begin : g_body
         assign rem_src = rem_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign den_src = den_ff[s-1];
         assign tag_src = tag_ff[s-1];
      end
      assign trial_in = {rem_src, quo_src[31]};
      assign diff_in = trial_in - {1'b0, den_src};
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!diff_in[32]) begin
               rem_ff[s] <= diff_in[31:0];
               quo_ff[s] <= {quo_src[30:0], 1'b1};
            end else begin
               rem_ff[s] <= trial_in[31:0];
               quo_ff[s] <= {quo_src[30:0], 1'b0};
            end
            den_ff[s] <= den_src;
            tag_ff[s] <= tag_src;
         end
      end
   end

   assign out_valid = v_ff[Steps-1];
   assign out_quo = quo_ff[Steps-1];
   assign out_rem = rem_ff[Steps-1];
   assign out_den = den_ff[Steps-1];
   assign out_tag = tag_ff[Steps-1];
endmodule

/* rtl/core/prescaler_and_compare_select.sv */
// Prescaler and compare value selection.
// Input channel req (pcs_req_if): one word carries wanted_freq in hertz.
// Result channel rsp (pcs_rsp_if): one word per input with select_code,
// divide_ratio, compare_top and status (0 ok, 1 above max_freq, 2 none).
// Configuration: csr_we, csr_index, csr_wdata; index 0 clock_hz, 1 max_freq.
// Write only while the block is idle.
// Throughput: one word per cycle unless the output register holds a word
// that rsp_ready has not taken. Pipeline: 32 stages of restoring division
// run in parallel for each prescaler, then range/round, one selection stage
// per prescaler (multiply and compare against the best so far) and the
// output register.
// Reset (synchronous, active high) empties the pipeline and loads
// clock_hz = 16000000 and max_freq = 65535.
// When the receiver stalls, the whole pipeline holds; req_ready follows
// rsp_ready or an empty output register, so nothing is lost or repeated.
module prescaler_and_compare_select #(
   parameter logic [31:0] COUNTER_MAX = pcs_pkg::CounterMaxDefault,
   parameter int unsigned NUM_PRESCALERS = pcs_pkg::NumPrescalersDefault
) (
   input  logic        clock,
   input  logic        reset,
   pcs_req_if.sink     req,
   pcs_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import pcs_pkg::*;

   localparam int unsigned NP = (NUM_PRESCALERS < RatioCount) ? NUM_PRESCALERS : RatioCount;

   logic [31:0] clock_hz_ff;
   logic [15:0] max_freq_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= ClockHzReset;
         max_freq_ff <= MaxFreqReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrClockHz: clock_hz_ff <= csr_wdata;
            CsrMaxFreq: max_freq_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic out_v_ff;
   result_type out_ff;
   assign adv = !out_v_ff || rsp.ready;
   assign req.ready = adv;

   // tag: too fast, zero freq
   logic [1:0] tag_in;
   assign tag_in = {req.wanted_freq > max_freq_ff, req.wanted_freq == 16'd0};

   logic        dv [NP];
   logic [31:0] dq [NP];
   logic [31:0] dr [NP];
   logic [31:0] dd [NP];
   logic [1:0]  dt [NP];

   // one divider per prescaler
   for (genvar i = 0; i < NP; i++) begin : g_div
      logic [31:0] den_in;
      assign den_in = {16'd0, req.wanted_freq} << ratio_shift(3'(i));
      pcs_div_pipe #(.TagW(2)) u_div (
         .clock(clock), .reset(reset), .adv(adv),
         .in_valid(req.valid && req.ready), .in_num(clock_hz_ff),
         .in_den(den_in), .in_tag(tag_in),
         .out_valid(dv[i]), .out_quo(dq[i]), .out_rem(dr[i]),
         .out_den(dd[i]), .out_tag(dt[i]));
   end

   // range check and rounding
   cand_type    c1_ff [NP];
   logic        v1_ff;
   logic [1:0]  t1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= dv[0];
   end
   for (genvar i = 0; i < NP; i++) begin : g_round
      logic ok_in;
      logic [32:0] r2_in;
      assign r2_in = {dr[i], 1'b0};
      assign ok_in = !dt[i][0] && dq[i] >= 32'd2 && (dq[i] - 32'd1) <= COUNTER_MAX
                     && !((dq[i] - 32'd1) == COUNTER_MAX && dr[i] != 32'd0);
      always_ff @(posedge clock) begin
         if (adv) begin
            c1_ff[i].ok <= ok_in;
            c1_ff[i].den <= dd[i];
            if (r2_in > {1'b0, dd[i]}) begin
               c1_ff[i].rounded <= dq[i];
               c1_ff[i].num <= dd[i] - dr[i];
            end else begin
               c1_ff[i].rounded <= dq[i] - 32'd1;
               c1_ff[i].num <= dr[i];
            end
         end
      end
   end
   always_ff @(posedge clock) if (adv) t1_ff <= dt[0];

   // sequential selection, one candidate per stage: multiply then compare
   localparam int unsigned Sel = NP;
   cand_type   bc_ff [Sel];
   logic [2:0] bi_ff [Sel];
   cand_type   pc_ff [Sel];
   logic [2:0] pi_ff [Sel];
   logic       v_ff  [Sel];
   logic [1:0] t_ff  [Sel];
   logic [63:0] lhs_ff [Sel];
   logic [63:0] rhs_ff [Sel];
   cand_type   rest_ff [Sel][NP];

   for (genvar s = 0; s < Sel; s++) begin : g_sel
      cand_type   best_prev;
      logic [2:0] bi_prev;
      cand_type   rest_prev [NP];
      logic       vp;
      logic [1:0] tp;
      if (s == 0) begin : g_first
         always_comb begin
            best_prev = '0;
            bi_prev = '0;
            vp = v1_ff;
            tp = t1_ff;
            for (int k = 0; k < NP; k++) rest_prev[k] = c1_ff[k];
         end
      end else begin : g_next
         logic take_in;
         assign take_in = pc_ff[s-1].ok && (!bc_ff[s-1].ok || lhs_ff[s-1] < rhs_ff[s-1]
                         || (lhs_ff[s-1] == rhs_ff[s-1]
                             && pc_ff[s-1].rounded < bc_ff[s-1].rounded));
         always_comb begin
            best_prev = take_in ? pc_ff[s-1] : bc_ff[s-1];
            bi_prev = take_in ? pi_ff[s-1] : bi_ff[s-1];
            vp = v_ff[s-1];
            tp = t_ff[s-1];
            for (int k = 0; k < NP; k++) rest_prev[k] = rest_ff[s-1][k];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else if (adv) v_ff[s] <= vp;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            bc_ff[s] <= best_prev;
            bi_ff[s] <= bi_prev;
            pc_ff[s] <= rest_prev[s];
            pi_ff[s] <= 3'(s + 1);
            t_ff[s] <= tp;
            lhs_ff[s] <= 64'(rest_prev[s].num) * 64'(best_prev.den);
            rhs_ff[s] <= 64'(best_prev.num) * 64'(rest_prev[s].den);
            for (int k = 0; k < NP; k++) rest_ff[s][k] <= rest_prev[k];
         end
      end
   end

   // final pick and output register
   logic take_last;
   cand_type fin;
   logic [2:0] fin_i;
   result_type res_in;
   assign take_last = pc_ff[Sel-1].ok && (!bc_ff[Sel-1].ok
                     || lhs_ff[Sel-1] < rhs_ff[Sel-1]
                     || (lhs_ff[Sel-1] == rhs_ff[Sel-1]
                         && pc_ff[Sel-1].rounded < bc_ff[Sel-1].rounded));
   assign fin = take_last ? pc_ff[Sel-1] : bc_ff[Sel-1];
   assign fin_i = take_last ? pi_ff[Sel-1] : bi_ff[Sel-1];
   always_comb begin
      res_in = '0;
      if (t_ff[Sel-1][1]) res_in.status = StatusTooFast;
      else if (!fin.ok) res_in.status = StatusNoPrescaler;
      else begin
         res_in.status = StatusOk;
         res_in.select_code = fin_i;
         res_in.divide_ratio = 11'd1 << ratio_shift(fin_i - 3'd1);
         res_in.compare_top = fin.rounded[15:0];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= v_ff[Sel-1];
   end
   always_ff @(posedge clock) if (adv) out_ff <= res_in;

   assign rsp.valid = out_v_ff;
   assign rsp.select_code = out_ff.select_code;
   assign rsp.divide_ratio = out_ff.divide_ratio;
   assign rsp.compare_top = out_ff.compare_top;
   assign rsp.status = out_ff.status;
endmodule

/* rtl/core/pcs_checker.sv */
module pcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_select_code,
   input logic [10:0] rsp_divide_ratio,
   input logic [15:0] rsp_compare_top,
   input logic [1:0]  rsp_status
);
   import pcs_pkg::*;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StatusOk |-> rsp_select_code == 3'd0
         && rsp_divide_ratio == 11'd0 && rsp_compare_top == 16'd0)
      else $error("error word carries nonzero fields");
   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == StatusOk |-> rsp_select_code != 3'd0
         && rsp_compare_top != 16'd0)
      else $error("ok word without prescaler");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled word changed");
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status");
endmodule

bind prescaler_and_compare_select pcs_checker u_pcs_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_select_code(rsp.select_code), .rsp_divide_ratio(rsp.divide_ratio),
   .rsp_compare_top(rsp.compare_top), .rsp_status(rsp.status));
